// File: src/rzs_pkg.sv
// Shared types, codes and datapath step functions for the sprite rotate-zoom setup.
// Used by every module of the block; depends on nothing.
package rzs_pkg;

	localparam int NSTAGE = 22;

	typedef enum logic [1:0] {
		ACT_SKIP    = 2'd0,
		ACT_DIRECT  = 2'd1,
		ACT_ROTZOOM = 2'd2
	} act_t;

	typedef enum logic [0:0] {
		CFG_VARIANT = 1'b0,
		CFG_PRIO    = 1'b1
	} cfg_idx_t;

	localparam logic [15:0] DELTA_UNITY = 16'h0100;
	localparam logic [15:0] Z_DEFAULT   = 16'h0100;

	typedef struct packed {
		act_t               act;
		logic [7:0]         color;
		logic               bpp8;
		logic [1:0]         flips;
		logic [15:0]        code;
		logic [5:0]         tiles_x;
		logic [5:0]         tiles_y;
		logic signed [9:0]  px;
		logic signed [9:0]  py;
		logic signed [15:0] dx;
		logic signed [16:0] dy;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		logic [15:0]        z;
		logic               neg_xx;
		logic               neg_yx;
		logic               neg_tx;
		logic               neg_ty;
	} side_t;

	typedef struct packed {
		logic [31:0] n;
		logic [31:0] r;
	} sq_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [31:0] qd;
	} dv_t;

	function automatic sq_t sqrt_step(sq_t a, int unsigned sh);
		logic [31:0] b;
		logic [31:0] t;
		sq_t res;
		b = 32'd1 << sh;
		t = a.r + b;
		res = a;
		if (a.n >= t) begin
			res.n = a.n - t;
			res.r = (a.r >> 1) + b;
		end else begin
			res.r = a.r >> 1;
		end
		return res;
	endfunction

	function automatic dv_t div_step(dv_t a, logic [15:0] d);
		logic [16:0] t;
		dv_t res;
		t = {a.rem, a.qd[31]};
		res.qd = {a.qd[30:0], 1'b0};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			res.qd[0] = 1'b1;
		end
		res.rem = t[15:0];
		return res;
	endfunction

endpackage

// File: src/rzs_front.sv
// Record decode, priority test, squares of the delta vector and their sum (stages 1 and 2).
// Depends on rzs_pkg.
module rzs_front import rzs_pkg::*; (
	input  logic        clk,
	input  logic [1:0]  en,
	input  logic        chip_variant,
	input  logic [3:0]  priority_mask,
	input  logic [7:0]  color_byte,
	input  logic [7:0]  control_byte,
	input  logic [15:0] tile_code,
	input  logic [15:0] size_x_word,
	input  logic [15:0] size_y_word,
	input  logic [15:0] delta_x,
	input  logic [15:0] delta_y,
	input  logic [15:0] source_x,
	input  logic [15:0] source_y,
	output side_t       side_s2,
	output logic [31:0] ssum_s2
);

	side_t              side_d;
	side_t              side_s1;
	logic               enable;
	logic               pass;
	logic               direct;
	logic               fx;
	logic               fy;
	logic signed [31:0] sqx;
	logic signed [33:0] sqy;
	logic [31:0]        sqx_s1;
	logic [31:0]        sqy_s1;

	always_comb begin
		side_d = '0;
		if (!chip_variant) begin
			enable = control_byte[2];
			side_d.color = {4'b0, color_byte[3:0]};
			side_d.bpp8 = control_byte[6];
			fx = control_byte[4];
			fy = control_byte[3];
		end else begin
			enable = |control_byte[3:2];
			side_d.color = color_byte;
			side_d.bpp8 = control_byte[3];
			fx = size_x_word[10];
			fy = size_y_word[10];
		end
		pass = enable && priority_mask[control_byte[1:0]];
		direct = (delta_x == DELTA_UNITY) && (delta_y == 16'd0) &&
			(source_x == 16'd0) && (source_y == 16'd0);
		if (!pass) begin
			side_d.act = ACT_SKIP;
		end else if (direct) begin
			side_d.act = ACT_DIRECT;
		end else begin
			side_d.act = ACT_ROTZOOM;
		end
		side_d.flips = {fy, fx};
		side_d.code = tile_code;
		side_d.tiles_x = {1'b0, size_x_word[15:11]} + 6'd1;
		side_d.tiles_y = {1'b0, size_y_word[15:11]} + 6'd1;
		side_d.px = size_x_word[9:0];
		side_d.py = size_y_word[9:0];
		side_d.dx = delta_x;
		side_d.dy = -$signed({delta_y[15], delta_y});
		side_d.ox = source_x;
		side_d.oy = source_y;
		sqx = side_d.dx * side_d.dx;
		sqy = side_d.dy * side_d.dy;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1 <= side_d;
			sqx_s1 <= sqx;
			sqy_s1 <= sqy[31:0];
		end
		if (en[1]) begin
			side_s2 <= side_s1;
			ssum_s2 <= sqx_s1 + sqy_s1;
		end
	end

endmodule

// File: src/rzs_sqrt.sv
// Pipelined integer square root, two result bits per stage over eight stages.
// Depends on rzs_pkg.
module rzs_sqrt import rzs_pkg::*; (
	input  logic        clk,
	input  logic [7:0]  en,
	input  logic [31:0] ssum,
	output logic [31:0] root,
	output logic [31:0] rem
);

	sq_t st [8];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st[0] <= sqrt_step(sqrt_step(sq_t'{n: ssum, r: 32'd0}, 30), 28);
		end
		for (int i = 1; i < 8; i++) begin
			if (en[i]) begin
				st[i] <= sqrt_step(sqrt_step(st[i-1], 30 - 4 * i), 28 - 4 * i);
			end
		end
	end

	assign root = st[7].r;
	assign rem = st[7].n;

endmodule

// File: src/rzs_div.sv
// Pipelined unsigned restoring divider, 32 by 16 bits, four quotient bits per stage.
// Depends on rzs_pkg.
module rzs_div import rzs_pkg::*; (
	input  logic        clk,
	input  logic [7:0]  en,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [31:0] quotient
);

	dv_t         st  [8];
	logic [15:0] dsr [7];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st[0] <= div_step(div_step(div_step(div_step(
				dv_t'{rem: 16'd0, qd: dividend}, divisor), divisor), divisor), divisor);
			dsr[0] <= divisor;
		end
		for (int i = 1; i < 8; i++) begin
			if (en[i]) begin
				st[i] <= div_step(div_step(div_step(div_step(
					st[i-1], dsr[i-1]), dsr[i-1]), dsr[i-1]), dsr[i-1]);
			end
		end
		for (int i = 1; i < 7; i++) begin
			if (en[i]) begin
				dsr[i] <= dsr[i-1];
			end
		end
	end

	assign quotient = st[7].qd;

endmodule

// File: src/sprite_rotozoom_setup.sv
// Top level of the sprite rotate-zoom setup pipeline.
// Depends on rzs_pkg, rzs_front, rzs_sqrt and rzs_div.
//
// One sprite record enters on the input channel (in_valid/in_ready) as its
// fields, and one set of draw parameters leaves on the output channel
// (out_valid/out_ready) for every record, in order.
// The pipeline has 22 register stages: decode and squares, sum, eight square
// root stages, rounding, eight divider stages, sign, products and the final
// start point add. The accepting edge loads the first stage, and the record
// then passes through the stages in order until out_valid rises for it.
// A new record may enter in every cycle while in_ready is high, so throughput
// is one transaction per cycle while the receiver keeps out_ready high; the
// sustained rate is set by the pipeline stages, each of which takes one record per cycle.
// When the receiver holds out_ready low, each stage keeps its record and
// empty stages ahead of it still fill, so in_ready falls only once every
// stage holds a record. Nothing is lost or repeated.
// Reset empties the pipeline and sets chip_variant to 0 and priority_mask to
// all ones. Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no record is in flight, as the block does not enforce it.
module sprite_rotozoom_setup import rzs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         color_byte,
	input  logic [7:0]         control_byte,
	input  logic [15:0]        tile_code,
	input  logic [15:0]        size_x_word,
	input  logic [15:0]        size_y_word,
	input  logic [15:0]        delta_x,
	input  logic [15:0]        delta_y,
	input  logic [15:0]        source_x,
	input  logic [15:0]        source_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         action,
	output logic [7:0]         palette_color,
	output logic               eight_bpp,
	output logic [1:0]         flip_bits,
	output logic [15:0]        first_code,
	output logic [5:0]         tiles_x,
	output logic [5:0]         tiles_y,
	output logic signed [31:0] start_x,
	output logic signed [31:0] start_y,
	output logic [22:0]        source_step,
	output logic signed [17:0] step_xx,
	output logic signed [17:0] step_yx
);

	logic               chip_variant_q;
	logic [3:0]         priority_mask_q;
	logic [NSTAGE:1]    stage_valid_q;
	logic [NSTAGE+1:1]  stage_rdy;

	side_t              side_s2;
	logic [31:0]        ssum_s2;
	side_t              side_s [3:NSTAGE-1];
	side_t              side_d11;
	logic [31:0]        root;
	logic [31:0]        rem;

	logic [15:0]        zr;
	logic [15:0]        mag_dx;
	logic [15:0]        mag_dy;
	logic [15:0]        mag_ox;
	logic [15:0]        mag_oy;
	logic [31:0]        dvd_xx_s11;
	logic [31:0]        dvd_yx_s11;
	logic [31:0]        dvd_tx_s11;
	logic [31:0]        dvd_ty_s11;
	logic [31:0]        q_xx;
	logic [31:0]        q_yx;
	logic [31:0]        q_tx;
	logic [31:0]        q_ty;

	logic signed [17:0] sxx_s20;
	logic signed [17:0] syx_s20;
	logic signed [24:0] tx_s20;
	logic signed [24:0] ty_s20;
	logic signed [17:0] hxx_s20;
	logic signed [17:0] hyx_s20;
	logic signed [42:0] pa;
	logic signed [42:0] pb;
	logic signed [42:0] pc;
	logic signed [42:0] pd;
	logic [31:0]        pa_s21;
	logic [31:0]        pb_s21;
	logic [31:0]        pc_s21;
	logic [31:0]        pd_s21;
	logic signed [17:0] hxx_s21;
	logic signed [17:0] hyx_s21;

	logic [31:0]        sx0;
	logic [31:0]        sy0;
	logic [1:0]         action_s22;
	logic [7:0]         color_s22;
	logic               bpp8_s22;
	logic [1:0]         flips_s22;
	logic [15:0]        code_s22;
	logic [5:0]         tiles_x_s22;
	logic [5:0]         tiles_y_s22;
	logic [31:0]        start_x_s22;
	logic [31:0]        start_y_s22;
	logic [22:0]        step_s22;
	logic [17:0]        hxx_s22;
	logic [17:0]        hyx_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_variant_q <= 1'b0;
			priority_mask_q <= 4'hf;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VARIANT: chip_variant_q <= cfg_data[0];
				CFG_PRIO:    priority_mask_q <= cfg_data;
				default:     chip_variant_q <= chip_variant_q;
			endcase
		end
	end

	always_comb begin
		stage_rdy[NSTAGE+1] = out_ready;
		for (int k = NSTAGE; k >= 1; k--) begin
			stage_rdy[k] = !stage_valid_q[k] || stage_rdy[k+1];
		end
	end

	assign in_ready = stage_rdy[1];
	assign out_valid = stage_valid_q[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_rdy[1]) begin
				stage_valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (stage_rdy[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	rzs_front u_front (
		.clk           (clk),
		.en            (stage_rdy[2:1]),
		.chip_variant  (chip_variant_q),
		.priority_mask (priority_mask_q),
		.color_byte    (color_byte),
		.control_byte  (control_byte),
		.tile_code     (tile_code),
		.size_x_word   (size_x_word),
		.size_y_word   (size_y_word),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.source_x      (source_x),
		.source_y      (source_y),
		.side_s2       (side_s2),
		.ssum_s2       (ssum_s2)
	);

	rzs_sqrt u_sqrt (
		.clk  (clk),
		.en   (stage_rdy[10:3]),
		.ssum (ssum_s2),
		.root (root),
		.rem  (rem)
	);

	always_comb begin
		zr = root[15:0] + {15'd0, (rem > root)};
		mag_dx = side_s[10].dx[15] ? 16'(-side_s[10].dx) : side_s[10].dx;
		mag_dy = side_s[10].dy[16] ? 16'(-side_s[10].dy) : side_s[10].dy[15:0];
		mag_ox = side_s[10].ox[15] ? 16'(-side_s[10].ox) : side_s[10].ox;
		mag_oy = side_s[10].oy[15] ? 16'(-side_s[10].oy) : side_s[10].oy;
		side_d11 = side_s[10];
		side_d11.z = (zr == 16'd0) ? Z_DEFAULT : zr;
		side_d11.neg_xx = side_s[10].dx < 0;
		side_d11.neg_yx = side_s[10].dy < 0;
		side_d11.neg_tx = side_s[10].ox > 0;
		side_d11.neg_ty = side_s[10].oy > 0;
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[3]) begin
			side_s[3] <= side_s2;
		end
		for (int k = 4; k <= 10; k++) begin
			if (stage_rdy[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
		for (int k = 12; k < NSTAGE; k++) begin
			if (stage_rdy[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
		if (stage_rdy[11]) begin
			side_s[11] <= side_d11;
			dvd_xx_s11 <= {mag_dx, 16'd0};
			dvd_yx_s11 <= {mag_dy, 16'd0};
			dvd_tx_s11 <= {8'd0, mag_ox, 8'd0};
			dvd_ty_s11 <= {8'd0, mag_oy, 8'd0};
		end
	end

	rzs_div u_div_xx (
		.clk (clk), .en (stage_rdy[19:12]), .dividend (dvd_xx_s11),
		.divisor (side_s[11].z), .quotient (q_xx)
	);
	rzs_div u_div_yx (
		.clk (clk), .en (stage_rdy[19:12]), .dividend (dvd_yx_s11),
		.divisor (side_s[11].z), .quotient (q_yx)
	);
	rzs_div u_div_tx (
		.clk (clk), .en (stage_rdy[19:12]), .dividend (dvd_tx_s11),
		.divisor (side_s[11].z), .quotient (q_tx)
	);
	rzs_div u_div_ty (
		.clk (clk), .en (stage_rdy[19:12]), .dividend (dvd_ty_s11),
		.divisor (side_s[11].z), .quotient (q_ty)
	);

	always_comb begin
		pa = tx_s20 * sxx_s20;
		pb = ty_s20 * syx_s20;
		pc = tx_s20 * syx_s20;
		pd = ty_s20 * sxx_s20;
		sx0 = {{6{side_s[21].px[9]}}, side_s[21].px, 16'd0};
		sy0 = {{6{side_s[21].py[9]}}, side_s[21].py, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[20]) begin
			sxx_s20 <= side_s[19].neg_xx ? -q_xx[17:0] : q_xx[17:0];
			syx_s20 <= side_s[19].neg_yx ? -q_yx[17:0] : q_yx[17:0];
			tx_s20 <= side_s[19].neg_tx ? -q_tx[24:0] : q_tx[24:0];
			ty_s20 <= side_s[19].neg_ty ? -q_ty[24:0] : q_ty[24:0];
			hxx_s20 <= side_s[19].neg_xx ? -q_xx[18:1] : q_xx[18:1];
			hyx_s20 <= side_s[19].neg_yx ? -q_yx[18:1] : q_yx[18:1];
		end
		if (stage_rdy[21]) begin
			pa_s21 <= pa[31:0];
			pb_s21 <= pb[31:0];
			pc_s21 <= pc[31:0];
			pd_s21 <= pd[31:0];
			hxx_s21 <= hxx_s20;
			hyx_s21 <= hyx_s20;
		end
		if (stage_rdy[22]) begin
			action_s22 <= side_s[21].act;
			if (side_s[21].act != ACT_SKIP) begin
				color_s22 <= side_s[21].color;
				bpp8_s22 <= side_s[21].bpp8;
				flips_s22 <= side_s[21].flips;
				code_s22 <= side_s[21].code;
				tiles_x_s22 <= side_s[21].tiles_x;
				tiles_y_s22 <= side_s[21].tiles_y;
			end else begin
				color_s22 <= '0;
				bpp8_s22 <= 1'b0;
				flips_s22 <= '0;
				code_s22 <= '0;
				tiles_x_s22 <= '0;
				tiles_y_s22 <= '0;
			end
			if (side_s[21].act == ACT_ROTZOOM) begin
				start_x_s22 <= sx0 + pa_s21 - pb_s21;
				start_y_s22 <= sy0 + pc_s21 + pd_s21;
				step_s22 <= {side_s[21].z, 7'd0};
				hxx_s22 <= hxx_s21;
				hyx_s22 <= hyx_s21;
			end else begin
				start_x_s22 <= (side_s[21].act == ACT_DIRECT) ? sx0 : '0;
				start_y_s22 <= (side_s[21].act == ACT_DIRECT) ? sy0 : '0;
				step_s22 <= '0;
				hxx_s22 <= '0;
				hyx_s22 <= '0;
			end
		end
	end

	assign action = action_s22;
	assign palette_color = color_s22;
	assign eight_bpp = bpp8_s22;
	assign flip_bits = flips_s22;
	assign first_code = code_s22;
	assign tiles_x = tiles_x_s22;
	assign tiles_y = tiles_y_s22;
	assign start_x = start_x_s22;
	assign start_y = start_y_s22;
	assign source_step = step_s22;
	assign step_xx = hxx_s22;
	assign step_yx = hyx_s22;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the sprite rotate-zoom setup block.
// Drives sprite records and register writes, predicts each draw parameter set in a
// scoreboard class and compares results in order. Depends on rzs_pkg and sprite_rotozoom_setup.
module testbench import rzs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]  colb;
		logic [7:0]  ctl;
		logic [15:0] code;
		logic [15:0] sxw;
		logic [15:0] syw;
		logic [15:0] ddx;
		logic [15:0] ddy;
		logic [15:0] srx;
		logic [15:0] sry;
	} record_t;

	typedef struct {
		logic [1:0]  act;
		logic [7:0]  color;
		logic        bpp8;
		logic [1:0]  flips;
		logic [15:0] code;
		logic [5:0]  tx;
		logic [5:0]  ty;
		logic [31:0] stx;
		logic [31:0] sty;
		logic [22:0] sstep;
		logic [17:0] sxx;
		logic [17:0] syx;
	} params_t;

	class draw_scoreboard;
		bit          newer_layout;
		logic [3:0]  prio_mask;
		params_t     pending[$];
		int          errors;

		function longint unsigned round_root(longint unsigned s);
			longint unsigned r, b, n;
			r = 0;
			n = s;
			b = 64'd1 << 30;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - r - b;
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			if (s > r * r + r) r = r + 1;
			return r;
		endfunction

		function void note_record(record_t rec);
			params_t p;
			bit en;
			longint dx, dy, ox, oy, z, sxx, syx, tx, ty, px, py;
			longint unsigned ssum;
			logic [31:0] sx0, sy0;
			p = '{default: '0};
			if (!newer_layout) begin
				en = rec.ctl[2];
				p.color = {4'h0, rec.colb[3:0]};
				p.bpp8 = rec.ctl[6];
				p.flips = {rec.ctl[3], rec.ctl[4]};
			end else begin
				en = rec.ctl[3:2] != 0;
				p.color = rec.colb;
				p.bpp8 = rec.ctl[3];
				p.flips = {rec.syw[10], rec.sxw[10]};
			end
			if (!en || !prio_mask[rec.ctl[1:0]]) begin
				pending.push_back(params_t'{default: '0});
				return;
			end
			p.code = rec.code;
			p.tx = rec.sxw[15:11] + 6'd1;
			p.ty = rec.syw[15:11] + 6'd1;
			px = $signed(rec.sxw[9:0]);
			py = $signed(rec.syw[9:0]);
			sx0 = 32'(px << 16);
			sy0 = 32'(py << 16);
			if (rec.ddx == DELTA_UNITY && rec.ddy == 0 && rec.srx == 0 && rec.sry == 0) begin
				p.act = ACT_DIRECT;
				p.stx = sx0;
				p.sty = sy0;
			end else begin
				dx = $signed(rec.ddx);
				dy = -longint'($signed(rec.ddy));
				ox = $signed(rec.srx);
				oy = $signed(rec.sry);
				ssum = (dx * dx + dy * dy) & 64'hffff_ffff;
				z = round_root(ssum);
				if (z == 0) z = Z_DEFAULT;
				sxx = (dx * 65536) / z;
				syx = (dy * 65536) / z;
				tx = (-ox * 256) / z;
				ty = (-oy * 256) / z;
				p.act = ACT_ROTZOOM;
				p.stx = sx0 + 32'(tx * sxx) + 32'(ty * -syx);
				p.sty = sy0 + 32'(tx * syx) + 32'(ty * sxx);
				p.sstep = 23'(z << 7);
				p.sxx = 18'(sxx / 2);
				p.syx = 18'(syx / 2);
			end
			pending.push_back(p);
		endfunction

		function void report(string field, logic [31:0] e, logic [31:0] g);
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, e, g);
			errors++;
		endfunction

		function void check_result(params_t got);
			params_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, action %0d", $time, got.act);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.act !== e.act) report("action", e.act, got.act);
			if (got.color !== e.color) report("palette_color", e.color, got.color);
			if (got.bpp8 !== e.bpp8) report("eight_bpp", e.bpp8, got.bpp8);
			if (got.flips !== e.flips) report("flip_bits", e.flips, got.flips);
			if (got.code !== e.code) report("first_code", e.code, got.code);
			if (got.tx !== e.tx) report("tiles_x", e.tx, got.tx);
			if (got.ty !== e.ty) report("tiles_y", e.ty, got.ty);
			if (got.stx !== e.stx) report("start_x", e.stx, got.stx);
			if (got.sty !== e.sty) report("start_y", e.sty, got.sty);
			if (got.sstep !== e.sstep) report("source_step", e.sstep, got.sstep);
			if (got.sxx !== e.sxx) report("step_xx", e.sxx, got.sxx);
			if (got.syx !== e.syx) report("step_yx", e.syx, got.syx);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [0:0] cfg_index = 0;
	logic [3:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [7:0] color_byte = 0, control_byte = 0;
	logic [15:0] tile_code = 0, size_x_word = 0, size_y_word = 0;
	logic [15:0] delta_x = 0, delta_y = 0, source_x = 0, source_y = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] action;
	logic [7:0] palette_color;
	logic eight_bpp;
	logic [1:0] flip_bits;
	logic [15:0] first_code;
	logic [5:0] tiles_x, tiles_y;
	logic signed [31:0] start_x, start_y;
	logic [22:0] source_step;
	logic signed [17:0] step_xx, step_yx;

	draw_scoreboard board = new();
	int idle_cycles = 0;
	int ready_gap = 0;
	bit hold_off = 0;

	sprite_rotozoom_setup dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic int gap_length();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [3:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_VARIANT) board.newer_layout = val[0];
		else board.prio_mask = val;
		@(posedge clk);
	endtask

	task automatic send_record(record_t rec, bit burst);
		int g;
		g = burst ? 0 : gap_length();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		color_byte <= rec.colb;
		control_byte <= rec.ctl;
		tile_code <= rec.code;
		size_x_word <= rec.sxw;
		size_y_word <= rec.syw;
		delta_x <= rec.ddx;
		delta_y <= rec.ddy;
		source_x <= rec.srx;
		source_y <= rec.sry;
		do @(posedge clk); while (!in_ready);
		board.note_record(rec);
	endtask

	function automatic record_t random_record();
		record_t r;
		r.colb = 8'($urandom);
		r.ctl = 8'($urandom);
		r.code = 16'($urandom);
		r.sxw = 16'($urandom);
		r.syw = 16'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				r.ddx = DELTA_UNITY;
				r.ddy = 16'd0;
				r.srx = 16'd0;
				r.sry = 16'd0;
			end
			1: begin
				r.ddx = 16'($urandom_range(0, 1023) - 512);
				r.ddy = 16'($urandom_range(0, 1023) - 512);
				r.srx = 16'($urandom_range(0, 255) - 128);
				r.sry = 16'($urandom_range(0, 255) - 128);
			end
			default: begin
				r.ddx = 16'($urandom);
				r.ddy = 16'($urandom);
				r.srx = 16'($urandom);
				r.sry = 16'($urandom);
			end
		endcase
		return r;
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (NSTAGE + 4) @(posedge clk);
	endtask

	task automatic run_phase(int count);
		for (int i = 0; i < count; i++) send_record(random_record(), hold_off);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_result(params_t'{action, palette_color, eight_bpp, flip_bits,
				first_code, tiles_x, tiles_y, start_x, start_y, source_step, step_xx,
				step_yx});
	end

	always @(posedge clk) begin
		if (hold_off) begin
			out_ready <= 0;
		end else if (ready_gap > 0) begin
			out_ready <= 0;
			ready_gap <= ready_gap - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 0;
		end else if ($urandom_range(0, 49) == 0) begin
			out_ready <= 0;
			ready_gap <= $urandom_range(10, 40);
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		record_t d;
		logic [15:0] edges[4] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff};
		board.newer_layout = 0;
		board.prio_mask = 4'hf;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed records: extremes, direct drawing, zero delta vector, disabled.
		for (int i = 0; i < 4; i++) begin
			d = '{edges[i][7:0], 8'hff, edges[i], edges[i], edges[i],
				edges[i], edges[i], edges[i], edges[i]};
			send_record(d, 0);
			d.ctl = 8'h00;
			send_record(d, 0);
		end
		d = '{8'hff, 8'h5c, 16'h1234, 16'hfdff, 16'h0200, DELTA_UNITY, 16'd0, 16'd0, 16'd0};
		send_record(d, 0);
		d.ddx = 16'd0;
		d.srx = 16'h7fff;
		send_record(d, 0);
		d = '{8'hff, 8'h57, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
		send_record(d, 0);
		drain();
		write_reg(CFG_VARIANT, 4'h1);
		write_reg(CFG_PRIO, 4'h0);
		run_phase(40);
		drain();
		write_reg(CFG_PRIO, 4'hf);
		run_phase(400);
		// Receiver holds off while the sender keeps offering records.
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			run_phase(60);
		join
		drain();
		write_reg(CFG_VARIANT, 4'h0);
		write_reg(CFG_PRIO, 4'h5);
		run_phase(300);
		drain();
		write_reg(CFG_PRIO, 4'hf);
		run_phase(400);
		drain();
		write_reg(CFG_VARIANT, 4'h1);
		write_reg(CFG_PRIO, 4'ha);
		run_phase(330);
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
